// File: hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the separator-set tokenizer
// Stream payloads, register indexes, split modes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Default depth of the inner-whitespace buffer
  localparam int SpaceBufDepth = 32;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int SepMapW  = 256;
  localparam int SepWordW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEP_0      = 3'd0,
    REG_SEP_1      = 3'd1,
    REG_SEP_2      = 3'd2,
    REG_SEP_3      = 3'd3,
    REG_SPLIT_MODE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_PLAIN    = 2'd0,
    MODE_NO_EMPTY = 2'd1,
    MODE_TRIM     = 2'd2
  } split_mode_e;

  // Input request payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;
  } in_item_t;

  // Result request payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_char;
    logic       token_end;
    logic       text_end;
    logic       space_dropped;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // latch the accepted request
    logic push_space;  // store the incoming whitespace byte
    logic mark_ovf;    // note a whitespace byte lost to a full buffer
    logic emit_byte;   // send the held token byte
    logic emit_flush;  // send the buffered whitespace byte at the read pointer
    logic close;       // close the current token
    logic close_last;  // the close also ends the text
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_has_byte;
    logic in_eot;
    logic in_sep;
    logic in_space;
    logic trim;
    logic seen_nonspace;
    logic cnt_zero;
    logic cnt_full;
    logic ptr_last;
    logic eot_q;
    logic slot_free;
  } ctrl_status_t;

endpackage

// File: hdl/cst_stream_if.sv
// ----------------------------------------------------------------------------
// cst_stream_if: valid/ready stream channel
// Carries one request payload of the given type from a source to a sink.
// ----------------------------------------------------------------------------
interface cst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/charset_split_tokenizer.sv
// Each result is registered: the step that makes it loads the output register.
// A request is accepted only when idle; a byte then takes a byte step and a close its own step.
// Held whitespace released by a byte takes a read and a write step per byte (single buffer read port).
// Results wait in the output register; the controller stalls only when that register is full.
// Reset: asynchronous, clears the bitmap, mode (plain) and token state; the
// whitespace buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// charset_split_tokenizer: separator-set text tokenizer
// Splits a byte stream into tokens at bitmap-selected separators, with plain,
// remove-empty and trim modes, and marks each token end.
// ----------------------------------------------------------------------------
module charset_split_tokenizer #(
  parameter int SPACE_BUF_DEPTH = cst_pkg::SpaceBufDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cst_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cst_pkg::CfgDataW-1:0] cfg_data_i,
  cst_stream_if.sink                   in_i,
  cst_stream_if.source                 out_o
);

  cst_pkg::ctrl_cmd_t    cmd;
  cst_pkg::ctrl_status_t status;
  cst_pkg::in_item_t     in_item;
  cst_pkg::out_item_t    out_item;
  logic                  in_ready;
  logic                  out_valid;

  assign in_item = in_i.payload;

  // Sequencer
  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, buffer and result path
  cst_datapath #(
    .SPACE_BUF_DEPTH (SPACE_BUF_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule

// File: hdl/cst_ctrl.sv
// ----------------------------------------------------------------------------
// cst_ctrl: tokenizer sequencer
// Accepts one request at a time and steps through whitespace flush, byte
// output and token closes, waiting on the result register as needed.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cst_pkg::ctrl_status_t status_i,
  output cst_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StByte = 3'd1;
  localparam logic [2:0] StFRd  = 3'd2;
  localparam logic [2:0] StFWr  = 3'd3;
  localparam logic [2:0] StCSep = 3'd4;
  localparam logic [2:0] StCEot = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.take = 1'b1;
          priority if (status_i.in_has_byte && status_i.in_sep) begin
            state_d = StCSep;
          end else if (status_i.in_has_byte && status_i.trim && !status_i.in_space) begin
            state_d = status_i.cnt_zero ? StByte : StFRd;
          end else if (status_i.in_has_byte && status_i.trim) begin
            // inner whitespace is held only after a non-space byte
            if (status_i.seen_nonspace) begin
              cmd_o.push_space = !status_i.cnt_full;
              cmd_o.mark_ovf   = status_i.cnt_full;
            end
            state_d = status_i.in_eot ? StCEot : StIdle;
          end else if (status_i.in_has_byte) begin
            state_d = StByte;
          end else begin
            state_d = status_i.in_eot ? StCEot : StIdle;
          end
        end
      end
      StByte: begin
        if (status_i.slot_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d = status_i.eot_q ? StCEot : StIdle;
        end
      end
      StFRd: begin
        // buffer read issued here, data ready next cycle
        state_d = StFWr;
      end
      StFWr: begin
        if (status_i.slot_free) begin
          cmd_o.emit_flush = 1'b1;
          state_d = status_i.ptr_last ? StByte : StFRd;
        end
      end
      StCSep: begin
        if (status_i.slot_free) begin
          cmd_o.close = 1'b1;
          state_d = status_i.eot_q ? StCEot : StIdle;
        end
      end
      StCEot: begin
        if (status_i.slot_free) begin
          cmd_o.close      = 1'b1;
          cmd_o.close_last = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/cst_datapath.sv
// ----------------------------------------------------------------------------
// cst_datapath: tokenizer registers and result path
// Holds the separator bitmap, mode, token state, the whitespace buffer and
// the result register; classifies incoming bytes for the controller.
// ----------------------------------------------------------------------------
module cst_datapath #(
  parameter int SPACE_BUF_DEPTH = cst_pkg::SpaceBufDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cst_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cst_pkg::CfgDataW-1:0]  cfg_data_i,
  input  cst_pkg::in_item_t             in_item_i,
  input  cst_pkg::ctrl_cmd_t            cmd_i,
  output cst_pkg::ctrl_status_t         status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cst_pkg::out_item_t            out_item_o
);

  localparam int CntW = $clog2(SPACE_BUF_DEPTH + 1);
  localparam int IdxW = (SPACE_BUF_DEPTH > 1) ? $clog2(SPACE_BUF_DEPTH) : 1;

  logic [cst_pkg::SepMapW-1:0] sep_map_q;
  logic [1:0]                  mode_q;

  logic            token_has_char_q;
  logic            seen_nonspace_q;
  logic            overflow_seen_q;
  logic            run_ovf_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] ptr_q;
  logic            eot_q;
  logic [7:0]      byte_q;

  logic [7:0]      space_mem [SPACE_BUF_DEPTH];
  logic [7:0]      rd_data_q;

  logic              out_valid_q;
  cst_pkg::out_item_t out_q;

  logic trim;
  logic drop;
  logic slot_free;
  logic in_space;
  logic out_load;

  assign trim      = (mode_q == cst_pkg::MODE_TRIM);
  assign drop      = (mode_q == cst_pkg::MODE_NO_EMPTY) && !token_has_char_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = cmd_i.emit_byte || cmd_i.emit_flush ||
                     (cmd_i.close && (!drop || cmd_i.close_last));

  // C-locale whitespace: tab through carriage return, and space
  assign in_space = (in_item_i.data_byte == 8'd32) ||
                    ((in_item_i.data_byte >= 8'd9) && (in_item_i.data_byte <= 8'd13));

  // Status towards the controller
  always_comb begin
    status_o.in_has_byte   = in_item_i.has_byte;
    status_o.in_eot        = in_item_i.end_of_text;
    status_o.in_sep        = sep_map_q[in_item_i.data_byte];
    status_o.in_space      = in_space;
    status_o.trim          = trim;
    status_o.seen_nonspace = seen_nonspace_q;
    status_o.cnt_zero      = (cnt_q == '0);
    status_o.cnt_full      = (cnt_q == CntW'(SPACE_BUF_DEPTH));
    status_o.ptr_last      = ((CntW'(ptr_q) + CntW'(1)) == cnt_q);
    status_o.eot_q         = eot_q;
    status_o.slot_free     = slot_free;
  end

  // Configuration registers; unlisted indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_map_q <= '0;
      mode_q    <= cst_pkg::MODE_PLAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cst_pkg::REG_SEP_0:
          sep_map_q[0*cst_pkg::SepWordW +: cst_pkg::SepWordW] <= cfg_data_i;
        cst_pkg::REG_SEP_1:
          sep_map_q[1*cst_pkg::SepWordW +: cst_pkg::SepWordW] <= cfg_data_i;
        cst_pkg::REG_SEP_2:
          sep_map_q[2*cst_pkg::SepWordW +: cst_pkg::SepWordW] <= cfg_data_i;
        cst_pkg::REG_SEP_3:
          sep_map_q[3*cst_pkg::SepWordW +: cst_pkg::SepWordW] <= cfg_data_i;
        cst_pkg::REG_SPLIT_MODE: mode_q <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  // Token state, buffer fill count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_has_char_q <= 1'b0;
      seen_nonspace_q  <= 1'b0;
      overflow_seen_q  <= 1'b0;
      run_ovf_q        <= 1'b0;
      cnt_q            <= '0;
      ptr_q            <= '0;
      eot_q            <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        eot_q <= in_item_i.end_of_text;
        ptr_q <= '0;
      end
      if (cmd_i.push_space) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.mark_ovf) begin
        run_ovf_q <= 1'b1;
      end
      if (cmd_i.emit_flush) begin
        ptr_q <= ptr_q + IdxW'(1);
      end
      if (cmd_i.emit_byte) begin
        token_has_char_q <= 1'b1;
        if (trim) begin
          seen_nonspace_q <= 1'b1;
          overflow_seen_q <= overflow_seen_q || run_ovf_q;
          run_ovf_q       <= 1'b0;
          cnt_q           <= '0;
        end
      end
      if (cmd_i.close) begin
        token_has_char_q <= 1'b0;
        seen_nonspace_q  <= 1'b0;
        overflow_seen_q  <= 1'b0;
        run_ovf_q        <= 1'b0;
        cnt_q            <= '0;
      end
    end
  end

  // Hold the token byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= in_item_i.data_byte;
    end
  end

  // Whitespace buffer: one write port, registered read at the pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_space) begin
      space_mem[cnt_q[IdxW-1:0]] <= in_item_i.data_byte;
    end
    rd_data_q <= space_mem[ptr_q];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      priority if (cmd_i.emit_byte) begin
        out_q <= '{out_byte: byte_q, has_char: 1'b1, token_end: 1'b0,
                   text_end: 1'b0, space_dropped: 1'b0};
      end else if (cmd_i.emit_flush) begin
        out_q <= '{out_byte: rd_data_q, has_char: 1'b1, token_end: 1'b0,
                   text_end: 1'b0, space_dropped: 1'b0};
      end else begin
        out_q <= '{out_byte: 8'd0, has_char: 1'b0, token_end: !drop,
                   text_end: cmd_i.close_last,
                   space_dropped: !drop && overflow_seen_q};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(SPACE_BUF_DEPTH))
    else $error("whitespace count beyond buffer depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_space |-> (cnt_q < CntW'(SPACE_BUF_DEPTH)))
    else $error("whitespace pushed into a full buffer");

  a_flush_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_flush |-> (CntW'(ptr_q) < cnt_q))
    else $error("flush read beyond stored whitespace");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |=> (cnt_q == '0) && !token_has_char_q && !overflow_seen_q)
    else $error("token state not cleared after close");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("result register overwritten while held");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the separator-set tokenizer
// Streams texts into the block under random valid/ready pressure, predicts
// the token bytes and token end markers of every accepted request, and checks
// each returned request against the oldest prediction. Runs a directed part
// over all modes and corner cases, then random texts under random settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [cst_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [cst_pkg::CfgDataW-1:0] cfg_data_i;

  cst_stream_if #(.payload_t(cst_pkg::in_item_t)) in_if ();
  cst_stream_if #(.payload_t(cst_pkg::out_item_t)) out_if ();

  charset_split_tokenizer u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending text bytes and the token output predicted for accepted requests
  cst_pkg::in_item_t text_q[$];
  cst_pkg::out_item_t token_out_q[$];

  // Tokenizer state as the bench sees it
  logic [cst_pkg::SepMapW-1:0] sep_map;
  logic [1:0] split_mode;
  logic tok_has_char;
  logic tok_seen_text;
  logic [7:0] held_ws[$];
  logic ws_lost_run;
  logic ws_lost_tok;

  // Handshake bookkeeping between the edges
  logic req_held = 1'b0;
  logic req_sent = 1'b0;
  logic res_taken = 1'b0;
  logic calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;

  function automatic void add_result(logic [7:0] b, logic hc, logic te, logic xe,
                                     logic sd);
    cst_pkg::out_item_t res;
    res.out_byte = b;
    res.has_char = hc;
    res.token_end = te;
    res.text_end = xe;
    res.space_dropped = sd;
    token_out_q = {token_out_q, res};
  endfunction

  // Close the current token; an empty one is dropped in remove-empty mode
  function automatic void close_token(logic last);
    if (!(split_mode == cst_pkg::MODE_NO_EMPTY && !tok_has_char)) begin
      add_result(8'h00, 1'b0, 1'b1, last, ws_lost_tok);
    end else if (last) begin
      add_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    end
    tok_has_char = 1'b0;
    tok_seen_text = 1'b0;
    held_ws.delete();
    ws_lost_run = 1'b0;
    ws_lost_tok = 1'b0;
  endfunction

  // Work out the token output of one accepted text request
  function automatic void tokenize_item(cst_pkg::in_item_t req);
    logic b_ws;
    b_ws = (req.data_byte == 8'd32) || (req.data_byte >= 8'd9 && req.data_byte <= 8'd13);
    if (req.has_byte) begin
      if (sep_map[req.data_byte]) begin
        close_token(1'b0);
      end else if (split_mode == cst_pkg::MODE_TRIM) begin
        if (b_ws) begin
          // hold inner whitespace until a later non-space byte
          if (tok_seen_text) begin
            if (held_ws.size() < cst_pkg::SpaceBufDepth) held_ws = {held_ws, req.data_byte};
            else ws_lost_run = 1'b1;
          end
        end else begin
          foreach (held_ws[i]) add_result(held_ws[i], 1'b1, 1'b0, 1'b0, 1'b0);
          if (ws_lost_run) ws_lost_tok = 1'b1;
          ws_lost_run = 1'b0;
          held_ws.delete();
          add_result(req.data_byte, 1'b1, 1'b0, 1'b0, 1'b0);
          tok_seen_text = 1'b1;
          tok_has_char = 1'b1;
        end
      end else begin
        add_result(req.data_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        tok_has_char = 1'b1;
      end
    end
    if (req.end_of_text) close_token(1'b1);
  endfunction

  function automatic void add_item(logic [7:0] b, logic hb, logic eot);
    cst_pkg::in_item_t req;
    req.data_byte = b;
    req.has_byte = hb;
    req.end_of_text = eot;
    text_q = {text_q, req};
  endfunction

  function automatic logic [7:0] pick_space();
    int unsigned v;
    v = $urandom_range(8, 13);
    return (v == 8) ? 8'd32 : 8'(v);
  endfunction

  function automatic void add_space_run(int unsigned len);
    repeat (len) add_item(pick_space(), 1'b1, 1'b0);
  endfunction

  // Write one register while the block is idle and mirror it
  task automatic write_reg(cst_pkg::cfg_reg_e idx, logic [cst_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cst_pkg::REG_SPLIT_MODE) split_mode = val[1:0];
    else sep_map[cst_pkg::SepWordW*idx +: cst_pkg::SepWordW] = val;
  endtask

  // Drain all pending and predicted requests, then let held work settle
  task automatic wait_idle();
    while (text_q.size() != 0 || req_held || token_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drive requests and ready at the falling edge
  always @(negedge clk_i) begin
    if (req_sent) begin
      req_held = 1'b0;
      req_sent = 1'b0;
    end
    if (!req_held) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (text_q.size() != 0) begin
        in_if.payload <= text_q.pop_front();
        req_held = 1'b1;
        if ($urandom_range(0, 19) == 0) calm = !calm;
        send_gap = calm ? 0 : $urandom_range(0, 14);
      end
    end
    in_if.valid <= req_held;
    if (res_taken) begin
      res_taken = 1'b0;
      recv_stall = calm ? 0 : $urandom_range(0, 14);
    end
    if (recv_stall != 0) begin
      recv_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Predict, check and watch for a hang at the rising edge
  always @(posedge clk_i) begin
    cst_pkg::out_item_t want;
    cst_pkg::out_item_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tokenize_item(in_if.payload);
        req_sent = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        res_taken = 1'b1;
        if (token_out_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result byte=%02h char=%b tok_end=%b txt_end=%b drop=%b",
                   $time, got.out_byte, got.has_char, got.token_end, got.text_end,
                   got.space_dropped);
        end else begin
          want = token_out_q.pop_front();
          if (got.out_byte !== want.out_byte || got.has_char !== want.has_char ||
              got.token_end !== want.token_end || got.text_end !== want.text_end ||
              got.space_dropped !== want.space_dropped) begin
            mismatches++;
            $display("%0t: mismatch expected byte=%02h char=%b tok_end=%b txt_end=%b drop=%b",
                     $time, want.out_byte, want.has_char, want.token_end, want.text_end,
                     want.space_dropped);
            $display("%0t: mismatch actual   byte=%02h char=%b tok_end=%b txt_end=%b drop=%b",
                     $time, got.out_byte, got.has_char, got.token_end, got.text_end,
                     got.space_dropped);
          end
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [cst_pkg::SepMapW-1:0] map;
    logic [7:0] sep_list[$];
    logic [7:0] b;
    logic [1:0] mode;
    int unsigned r;
    int ph;
    int n;

    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    sep_map = '0;
    split_mode = cst_pkg::MODE_PLAIN;
    tok_has_char = 1'b0;
    tok_seen_text = 1'b0;
    ws_lost_run = 1'b0;
    ws_lost_tok = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Plain mode: byte extremes as separators, ends in all forms
    write_reg(cst_pkg::REG_SEP_0, (64'd1 << 44) | 64'd1);
    write_reg(cst_pkg::REG_SEP_1, 64'd0);
    write_reg(cst_pkg::REG_SEP_2, 64'd0);
    write_reg(cst_pkg::REG_SEP_3, 64'd1 << 63);
    write_reg(cst_pkg::REG_SPLIT_MODE, cst_pkg::MODE_PLAIN);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'h2C, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h7A, 1'b1, 1'b1);
    add_item(8'h2C, 1'b1, 1'b1);
    add_item(8'h55, 1'b0, 1'b1);
    wait_idle();

    // Remove-empty mode: dropped empty tokens and bare text end markers
    write_reg(cst_pkg::REG_SPLIT_MODE, cst_pkg::MODE_NO_EMPTY);
    add_item(8'h2C, 1'b1, 1'b0);
    add_item(8'h2C, 1'b1, 1'b0);
    add_item(8'h71, 1'b1, 1'b0);
    add_item(8'h2C, 1'b1, 1'b1);
    add_item(8'hAA, 1'b0, 1'b1);
    wait_idle();

    // Trim mode: edges stripped, inner space kept, buffer overflow both ways
    write_reg(cst_pkg::REG_SPLIT_MODE, cst_pkg::MODE_TRIM);
    add_item(8'd32, 1'b1, 1'b0);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'd32, 1'b1, 1'b0);
    add_item(8'd9, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'd13, 1'b1, 1'b0);
    add_item(8'h2C, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b0);
    add_space_run(cst_pkg::SpaceBufDepth + 1);
    add_item(8'h64, 1'b1, 1'b1);
    add_item(8'h65, 1'b1, 1'b0);
    add_space_run(cst_pkg::SpaceBufDepth + 1);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h66, 1'b1, 1'b0);
    add_item(8'd32, 1'b1, 1'b0);
    add_item(8'd32, 1'b1, 1'b0);
    wait_idle();

    // Switch to the undefined mode in mid-token: held space is discarded
    write_reg(cst_pkg::REG_SPLIT_MODE, 2'd3);
    add_item(8'd32, 1'b1, 1'b0);
    add_item(8'h67, 1'b1, 1'b0);
    add_item(8'h2C, 1'b1, 1'b0);
    wait_idle();

    // Random texts under varied separator sets and modes
    for (ph = 0; ph < 8; ph++) begin
      sep_list.delete();
      case (ph % 4)
        0: begin
          map = '0;
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(0, 255));
            map[b] = 1'b1;
            sep_list = {sep_list, b};
          end
        end
        1: map = '1;
        2: map = '0;
        default: begin
          for (n = 0; n < cst_pkg::SepMapW / 32; n++) map[32*n +: 32] = $urandom;
        end
      endcase
      mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      for (n = 0; n < cst_pkg::SepMapW / cst_pkg::SepWordW; n++) begin
        write_reg(cst_pkg::cfg_reg_e'(n), map[cst_pkg::SepWordW*n +: cst_pkg::SepWordW]);
      end
      write_reg(cst_pkg::REG_SPLIT_MODE, mode);

      n = 0;
      while (n < 6) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          // long whitespace run to press on the buffer limit
          add_space_run($urandom_range(20, 40));
          b = 8'($urandom_range(33, 126));
        end else if (r < 15) begin
          b = (sep_list.size() != 0) ? sep_list[$urandom_range(0, sep_list.size() - 1)]
                                     : 8'($urandom_range(0, 255));
        end else if (r < 40) begin
          b = pick_space();
        end else if (r < 55) begin
          b = 8'($urandom_range(0, 255));
        end else begin
          b = 8'($urandom_range(33, 126));
        end
        if ($urandom_range(0, 24) == 0) begin
          add_item(b, 1'b0, 1'($urandom_range(0, 1)));
        end else begin
          add_item(b, 1'b1, ($urandom_range(0, 15) == 0));
        end
        if (text_q[$].has_byte || text_q[$].end_of_text) n++;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
